// ----- src/arps_pkg.sv -----
package arps_pkg;

  localparam int DEFAULT_SLOTS = 8;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_MASK = 2'd1;
  localparam logic [1:0] CMD_POLL = 2'd2;

  localparam logic [3:0] ADDR_RATE     = 4'd0;
  localparam logic [3:0] ADDR_FUEL     = 4'd4;
  localparam logic [3:0] ADDR_THROTTLE = 4'd8;

  localparam logic [7:0]  RATE_RESET    = 8'd10;
  localparam logic [7:0]  ID_LAST       = 8'h60;
  localparam logic [7:0]  ID_FUEL_A     = 8'h06;
  localparam logic [7:0]  ID_FUEL_B     = 8'h07;
  localparam logic [7:0]  ID_THROTTLE   = 8'h11;
  localparam logic [15:0] PARKED_IV     = 16'd1000;
  localparam logic [31:0] GAP_FLOOR     = 32'd20;
  localparam logic [40:0] GAP_NUMERATOR = 41'd1000;
  localparam int          MASK_GROUPS   = 3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  entry_index;
    logic [7:0]  entry_ident;
    logic [15:0] entry_interval_ms;
    logic [1:0]  mask_group;
    logic [31:0] mask_bits;
    logic [31:0] now_ms;
    logic        parked;
  } in_t;

  typedef struct packed {
    logic       grant;
    logic [7:0] granted_ident;
    logic [2:0] granted_slot;
  } out_t;

  typedef struct packed {
    logic [7:0]  ident;
    logic [15:0] interval;
    logic [31:0] last;
  } slot_t;

  typedef struct packed {
    logic        shift;
    logic        load;
    logic [7:0]  load_ident;
    logic [15:0] load_interval;
    logic        grant_wr;
    logic [31:0] now;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_GAP,
    ST_DONE
  } state_t;

endpackage

// ----- src/age_ratio_poll_scheduler_unit.sv -----
// Poll tick: the slot ring turns twice so that one slot per cycle is scored in
// rotation order from the cursor, then the drain, gap and done states follow.
// Load, mask and other commands go straight from idle to the done state.
// One transaction at a time; the next is taken once the result is registered.
// Synchronous active-high reset clears the slot table, cursor, last request
// time, state and valid flags; support masks stay unknown until stored.
module age_ratio_poll_scheduler_unit #(
  parameter int SLOTS = arps_pkg::DEFAULT_SLOTS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  arps_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output arps_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(2 * SLOTS + 1);
  localparam logic [CW-1:0] K_LAST = CW'(2 * SLOTS - 1);
  localparam logic [CW-1:0] K_SLOTS = CW'(SLOTS);
  localparam logic [IW-1:0] I_LAST = IW'(SLOTS - 1);

  arps_pkg::state_t state, state_next;

  logic [7:0]  rate;
  logic        fuel_en;
  logic        thr_en;
  logic [31:0] support_mask [arps_pkg::MASK_GROUPS];
  logic [2:0]  mask_valid;
  logic [IW-1:0] cursor;
  logic [31:0] last_req;

  logic [31:0] it_now;
  logic        it_parked;
  logic [CW-1:0] k;

  logic          c_vld;
  logic [31:0]   c_age;
  logic [15:0]   c_iv;
  logic [IW-1:0] c_idx;

  logic          found;
  logic [IW-1:0] best;
  logic [31:0]   best_age;
  logic [15:0]   best_int;
  logic [31:0]   gap_d;

  arps_pkg::slot_t     q [SLOTS];
  arps_pkg::cell_ctl_t ctl [SLOTS];

  logic accept, fire, ok;

  assign pready   = 1'b1;
  assign in_stall = (state != arps_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign fire     = (state == arps_pkg::ST_DONE) && (!out_valid || !out_stall);

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      rate    <= arps_pkg::RATE_RESET;
      fuel_en <= 1'b0;
      thr_en  <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        arps_pkg::ADDR_RATE:     rate    <= pwdata[7:0];
        arps_pkg::ADDR_FUEL:     fuel_en <= pwdata[0];
        arps_pkg::ADDR_THROTTLE: thr_en  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      arps_pkg::ADDR_RATE:     prdata = {24'd0, rate};
      arps_pkg::ADDR_FUEL:     prdata = {31'd0, fuel_en};
      arps_pkg::ADDR_THROTTLE: prdata = {31'd0, thr_en};
      default:                 prdata = '0;
    endcase
  end

  // slot ring
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    always_comb begin
      ctl[i].shift         = (state == arps_pkg::ST_SCAN);
      ctl[i].load          = accept && (in_data.cmd == arps_pkg::CMD_LOAD) &&
                             (32'(in_data.entry_index) == i);
      ctl[i].load_ident    = in_data.entry_ident;
      ctl[i].load_interval = in_data.entry_interval_ms;
      ctl[i].grant_wr      = fire && ok && (32'(best) == i);
      ctl[i].now           = it_now;
    end
    arps_cell u_cell (
      .clk (clk),
      .rst (rst),
      .ctl (ctl[i]),
      .nbr (q[(i + 1) % SLOTS]),
      .q   (q[i])
    );
  end

  // score the slot at the head of the ring
  logic [7:0]    id, id_m1;
  logic [1:0]    grp;
  logic [4:0]    bitn;
  logic          sup, excl, in_win;
  logic [15:0]   iv;
  logic [31:0]   age;
  logic [CW:0]   win_end;
  logic [IW-1:0] k_idx;

  always_comb begin
    id      = q[0].ident;
    id_m1   = id - 8'd1;
    grp     = id_m1[6:5];
    bitn    = 5'd31 - id_m1[4:0];
    sup     = (id != 8'd0) && (id <= arps_pkg::ID_LAST) &&
              (!mask_valid[grp] || support_mask[grp][bitn]);
    excl    = (((id == arps_pkg::ID_FUEL_A) || (id == arps_pkg::ID_FUEL_B)) && !fuel_en) ||
              ((id == arps_pkg::ID_THROTTLE) && !thr_en);
    iv      = (it_parked && (q[0].interval < arps_pkg::PARKED_IV)) ?
              arps_pkg::PARKED_IV : q[0].interval;
    age     = it_now - q[0].last;
    win_end = (CW+1)'(cursor) + (CW+1)'(SLOTS);
    in_win  = ((CW+1)'(k) >= (CW+1)'(cursor)) && ((CW+1)'(k) < win_end);
    k_idx   = (k >= K_SLOTS) ? IW'(k - K_SLOTS) : IW'(k);
  end

  logic [47:0] pa, pb;
  assign pa = c_age * 48'(best_int);
  assign pb = best_age * 48'(c_iv);

  logic [7:0]  rate_eff;
  logic [40:0] gap_prod;
  assign rate_eff = (rate == 8'd0) ? 8'd1 : rate;
  assign gap_prod = (41'(gap_d) + 41'd1) * 41'(rate_eff);
  assign ok       = found && (gap_d >= arps_pkg::GAP_FLOOR) &&
                    (gap_prod > arps_pkg::GAP_NUMERATOR);

  always_comb begin
    state_next = state;
    unique case (state)
      arps_pkg::ST_IDLE:  if (accept) begin
        state_next = (in_data.cmd == arps_pkg::CMD_POLL) ?
                     arps_pkg::ST_SCAN : arps_pkg::ST_DONE;
      end
      arps_pkg::ST_SCAN:  if (k == K_LAST) state_next = arps_pkg::ST_DRAIN;
      arps_pkg::ST_DRAIN: state_next = arps_pkg::ST_GAP;
      arps_pkg::ST_GAP:   state_next = arps_pkg::ST_DONE;
      arps_pkg::ST_DONE:  if (fire) state_next = arps_pkg::ST_IDLE;
      default:            state_next = arps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= arps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_valid <= '0;
      cursor     <= '0;
      last_req   <= '0;
      found      <= 1'b0;
      c_vld      <= 1'b0;
      k          <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        it_now    <= in_data.now_ms;
        it_parked <= in_data.parked;
        found     <= 1'b0;
        k         <= '0;
        if ((in_data.cmd == arps_pkg::CMD_MASK) &&
            (32'(in_data.mask_group) < arps_pkg::MASK_GROUPS)) begin
          mask_valid[in_data.mask_group] <= 1'b1;
        end
      end
      if (state == arps_pkg::ST_SCAN) begin
        k     <= k + CW'(1);
        c_vld <= in_win && sup && !excl && (age >= 32'(iv));
        c_age <= age;
        c_iv  <= iv;
        c_idx <= k_idx;
      end else begin
        c_vld <= 1'b0;
      end
      // keep the first best in rotation order: replace on strictly greater
      if (c_vld && (!found || (pa > pb))) begin
        found    <= 1'b1;
        best     <= c_idx;
        best_age <= c_age;
        best_int <= c_iv;
      end
      if (state == arps_pkg::ST_GAP) gap_d <= it_now - last_req;
      if (fire) begin
        if (ok) begin
          last_req                <= it_now;
          cursor                  <= (best == I_LAST) ? '0 : best + IW'(1);
          out_data.grant          <= 1'b1;
          out_data.granted_ident  <= q[best].ident;
          out_data.granted_slot   <= 3'(best);
        end else begin
          out_data <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_data.cmd == arps_pkg::CMD_MASK) &&
        (32'(in_data.mask_group) < arps_pkg::MASK_GROUPS)) begin
      support_mask[in_data.mask_group] <= in_data.mask_bits;
    end
  end

endmodule

// ----- src/arps_cell.sv -----
module arps_cell (
  input  logic               clk,
  input  logic               rst,
  input  arps_pkg::cell_ctl_t ctl,
  input  arps_pkg::slot_t    nbr,
  output arps_pkg::slot_t    q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctl.load) begin
      q.ident    <= ctl.load_ident;
      q.interval <= ctl.load_interval;
      q.last     <= '0;
    end else if (ctl.grant_wr) begin
      q.last <= ctl.now;
    end else if (ctl.shift) begin
      q <= nbr;
    end
  end

endmodule
